// ===== rtl/core/ilid_pkg.sv =====
package ilid_pkg;

  localparam int unsigned Capacity = 64;

  typedef enum logic [2:0] {
    OP_READ     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_AT   = 3'd3,
    OP_DELETE   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_RESP
  } state_e;

endpackage

// ===== rtl/core/indexed_list_insert_delete.sv =====
// A read passes through the fetch state to the response; an insert shifts the entries
// from the position up one place, one read/write state pair per entry, then writes the
// item; a delete shifts the entries after the position down one place; out-of-range,
// full and unused opcodes go straight to the response. One item at a time: the next item
// is taken once the result transfer completes. Reset: the entry count clears at once;
// store contents stay undefined until written, no clearing pass.
module indexed_list_insert_delete #(
  parameter int unsigned CAPACITY = ilid_pkg::Capacity,
  localparam int unsigned PosW    = $clog2(CAPACITY + 1),
  localparam int unsigned InW     = ((3 + PosW + 32 + 7) / 8) * 8,
  localparam int unsigned OutW    = ((32 + 2 + PosW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // opcode[3], position[PosW], item_value[32], zero pad
  input  logic [InW-1:0]  s_axis_tdata_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  // read_value[32], status[2], entry_count[PosW], zero pad
  output logic [OutW-1:0] m_axis_tdata_o
);

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [PosW-1:0] CapVal = PosW'(CAPACITY);
  localparam logic [PosW-1:0] One    = PosW'(1);

  ilid_pkg::state_e state_q, state_d;
  logic [PosW-1:0]  cnt_q, cnt_d;
  logic [PosW-1:0]  idx_q, idx_d;
  logic [PosW-1:0]  lim_q, lim_d;
  logic             del_q, del_d;
  logic             rd_ok_q, rd_ok_d;
  logic [31:0]      val_q, val_d;
  ilid_pkg::status_e st_q, st_d;

  logic [31:0] mem [CAPACITY];
  logic [31:0] rdata_q;
  logic        rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_data;

  ilid_pkg::op_e   in_op;
  logic [PosW-1:0] in_pos;
  logic [31:0]     in_val;
  logic            accept;
  logic [PosW-1:0] ins_pos;
  logic [PosW-1:0] nxt_idx;
  logic            cont;

  assign in_op  = ilid_pkg::op_e'(s_axis_tdata_i[2:0]);
  assign in_pos = s_axis_tdata_i[3 +: PosW];
  assign in_val = s_axis_tdata_i[3 + PosW +: 32];
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  assign nxt_idx = del_q ? (idx_q + One) : (idx_q - One);
  assign cont    = del_q ? (nxt_idx < lim_q) : (nxt_idx > lim_q);

  always_comb begin
    case (in_op)
      ilid_pkg::OP_INS_HEAD: ins_pos = '0;
      ilid_pkg::OP_INS_TAIL: ins_pos = cnt_q;
      default:               ins_pos = in_pos;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    lim_d   = lim_q;
    del_d   = del_q;
    rd_ok_d = rd_ok_q;
    val_d   = val_q;
    st_d    = st_q;
    case (state_q)
      ilid_pkg::S_IDLE: begin
        if (accept) begin
          rd_ok_d = 1'b0;
          val_d   = in_val;
          st_d    = ilid_pkg::ST_DONE;
          state_d = ilid_pkg::S_RESP;
          case (in_op)
            ilid_pkg::OP_READ: begin
              if (in_pos < cnt_q) begin
                rd_ok_d = 1'b1;
                state_d = ilid_pkg::S_FETCH;
              end else begin
                st_d = ilid_pkg::ST_RANGE;
              end
            end
            ilid_pkg::OP_INS_HEAD, ilid_pkg::OP_INS_TAIL, ilid_pkg::OP_INS_AT: begin
              del_d = 1'b0;
              idx_d = cnt_q;
              lim_d = ins_pos;
              if (ins_pos > cnt_q) begin
                st_d = ilid_pkg::ST_RANGE;
              end else if (cnt_q == CapVal) begin
                st_d = ilid_pkg::ST_FULL;
              end else if (cnt_q > ins_pos) begin
                state_d = ilid_pkg::S_SHIFT_RD;
              end else begin
                state_d = ilid_pkg::S_PUT;
              end
            end
            ilid_pkg::OP_DELETE: begin
              del_d = 1'b1;
              idx_d = in_pos;
              lim_d = cnt_q - One;
              if (in_pos >= cnt_q) begin
                st_d = ilid_pkg::ST_RANGE;
              end else begin
                cnt_d = cnt_q - One;
                if (in_pos < cnt_q - One) begin
                  state_d = ilid_pkg::S_SHIFT_RD;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ilid_pkg::S_FETCH:    state_d = ilid_pkg::S_RESP;
      ilid_pkg::S_SHIFT_RD: state_d = ilid_pkg::S_SHIFT_WR;
      ilid_pkg::S_SHIFT_WR: begin
        idx_d = nxt_idx;
        if (cont) begin
          state_d = ilid_pkg::S_SHIFT_RD;
        end else if (del_q) begin
          state_d = ilid_pkg::S_RESP;
        end else begin
          state_d = ilid_pkg::S_PUT;
        end
      end
      ilid_pkg::S_PUT: begin
        cnt_d   = cnt_q + One;
        state_d = ilid_pkg::S_RESP;
      end
      ilid_pkg::S_RESP: begin
        if (m_axis_tready_i) begin
          state_d = ilid_pkg::S_IDLE;
        end
      end
      default: state_d = ilid_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = nxt_idx[AddrW-1:0];
    wr_en           = 1'b0;
    wr_addr         = idx_q[AddrW-1:0];
    wr_data         = rdata_q;
    case (state_q)
      ilid_pkg::S_IDLE: s_axis_tready_o = 1'b1;
      ilid_pkg::S_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = idx_q[AddrW-1:0];
      end
      ilid_pkg::S_SHIFT_RD: rd_en = 1'b1;
      ilid_pkg::S_SHIFT_WR: wr_en = 1'b1;
      ilid_pkg::S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = lim_q[AddrW-1:0];
        wr_data = val_q;
      end
      ilid_pkg::S_RESP: m_axis_tvalid_o = 1'b1;
      default: ;
    endcase
  end

  // read position travels through idx for the fetch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ilid_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= (state_q == ilid_pkg::S_IDLE && accept && in_op == ilid_pkg::OP_READ)
               ? in_pos : idx_d;
    lim_q   <= lim_d;
    del_q   <= del_d;
    rd_ok_q <= rd_ok_d;
    val_q   <= val_d;
    st_q    <= st_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[31:0]         = rd_ok_q ? rdata_q : 32'd0;
    m_axis_tdata_o[33:32]        = st_q;
    m_axis_tdata_o[34 +: PosW]   = cnt_q;
  end

endmodule

// ===== dv/ilid_checker.sv =====
module ilid_checker #(
  parameter int unsigned CAPACITY = ilid_pkg::Capacity,
  localparam int unsigned PosW    = $clog2(CAPACITY + 1),
  localparam int unsigned InW     = ((3 + PosW + 32 + 7) / 8) * 8,
  localparam int unsigned OutW    = ((32 + 2 + PosW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  input  logic            s_axis_tready_i,
  // opcode[3], position[PosW], item_value[32], zero pad
  input  logic [InW-1:0]  s_axis_tdata_i,
  input  logic            m_axis_tvalid_i,
  input  logic            m_axis_tready_i,
  // read_value[32], status[2], entry_count[PosW], zero pad
  input  logic [OutW-1:0] m_axis_tdata_i,
  output int              errors_o,
  output int              pending_o,
  output logic [PosW-1:0] fill_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AddrW = $clog2(CAPACITY);

  typedef struct packed {
    logic [31:0]       read_value;
    ilid_pkg::status_e status;
    logic [PosW-1:0]   entry_count;
  } list_reply_t;

  logic [31:0]     mirror_entries [CAPACITY];
  logic [PosW-1:0] mirror_count = '0;
  list_reply_t     due_replies [$];
  int              mismatches = 0;

  function automatic list_reply_t apply_list_op(input logic [2:0] op,
                                                input logic [PosW-1:0] pos,
                                                input logic [31:0] val);
    list_reply_t     reply;
    logic [PosW-1:0] at;
    bit              grows;
    reply.read_value = '0;
    reply.status     = ilid_pkg::ST_DONE;
    grows            = 1'b0;
    at               = pos;
    case (op)
      ilid_pkg::OP_READ: begin
        if (pos < mirror_count) reply.read_value = mirror_entries[pos[AddrW-1:0]];
        else reply.status = ilid_pkg::ST_RANGE;
      end
      ilid_pkg::OP_INS_HEAD: begin
        grows = 1'b1;
        at    = '0;
      end
      ilid_pkg::OP_INS_TAIL: begin
        grows = 1'b1;
        at    = mirror_count;
      end
      ilid_pkg::OP_INS_AT: begin
        grows = 1'b1;
      end
      ilid_pkg::OP_DELETE: begin
        if (pos >= mirror_count) begin
          reply.status = ilid_pkg::ST_RANGE;
        end else begin
          for (int i = int'(pos); i < int'(mirror_count) - 1; i++) begin
            mirror_entries[i] = mirror_entries[i + 1];
          end
          mirror_count = mirror_count - 1'b1;
        end
      end
      default: ;
    endcase
    if (grows) begin
      if (at > mirror_count) begin
        reply.status = ilid_pkg::ST_RANGE;
      end else if (mirror_count >= CAPACITY) begin
        reply.status = ilid_pkg::ST_FULL;
      end else begin
        for (int i = int'(mirror_count); i > int'(at); i--) mirror_entries[i] = mirror_entries[i - 1];
        mirror_entries[at[AddrW-1:0]] = val;
        mirror_count                  = mirror_count + 1'b1;
      end
    end
    reply.entry_count = mirror_count;
    return reply;
  endfunction

  always @(posedge clk_i) begin
    list_reply_t     want;
    logic [31:0]     got_value;
    logic [1:0]      got_status;
    logic [PosW-1:0] got_count;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        due_replies.push_back(apply_list_op(s_axis_tdata_i[2:0], s_axis_tdata_i[3 +: PosW],
                                            s_axis_tdata_i[3 + PosW +: 32]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_value  = m_axis_tdata_i[31:0];
        got_status = m_axis_tdata_i[33:32];
        got_count  = m_axis_tdata_i[34 +: PosW];
        if (due_replies.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer, expected none, got value %h status %0d count %0d",
                   $time, got_value, got_status, got_count);
        end else begin
          want = due_replies.pop_front();
          if (got_value !== want.read_value) begin
            mismatches++;
            $display("%0t: read_value expected %h, got %h", $time, want.read_value, got_value);
          end
          if (got_status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, got_status);
          end
          if (got_count !== want.entry_count) begin
            mismatches++;
            $display("%0t: entry_count expected %0d, got %0d", $time, want.entry_count,
                     got_count);
          end
        end
      end
      errors_o  <= mismatches;
      pending_o <= due_replies.size();
      fill_o    <= mirror_count;
    end else begin
      errors_o  <= mismatches;
      pending_o <= 0;
      fill_o    <= '0;
    end
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap         = ilid_pkg::Capacity;
  localparam int unsigned PosW        = $clog2(Cap + 1);
  localparam int unsigned InW         = ((3 + PosW + 32 + 7) / 8) * 8;
  localparam int unsigned OutW        = ((32 + 2 + PosW + 7) / 8) * 8;
  localparam int          NumItems    = 1150;
  localparam int          PhaseLen    = 200;
  localparam int          MaxCycles   = 1_000_000;
  localparam int          DrainCycles = 2 * Cap + 16;

  logic            clk;
  logic            rst_n;
  logic            s_valid;
  logic            s_ready;
  logic [InW-1:0]  s_data;
  logic            m_valid;
  logic            m_ready;
  logic [OutW-1:0] m_data;
  int              errors;
  int              pending;
  logic [PosW-1:0] fill;
  int              cycles = 0;
  bit              send_steady = 1'b0;

  indexed_list_insert_delete u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  ilid_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_i(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_i(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_i (m_data),
    .errors_o       (errors),
    .pending_o      (pending),
    .fill_o         (fill)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MaxCycles) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] op, input logic [PosW-1:0] pos,
                           input logic [31:0] val);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= InW'({val, pos, op});
    do @(posedge clk); while (!s_ready);
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    bit stall_steady;
    int stall;
    m_ready      = 1'b0;
    stall_steady = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = stall_steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
      if ($urandom_range(0, 39) == 0) stall_steady = !stall_steady;
    end
  end

  initial begin
    int          counted;
    int          phase_left;
    int          target;
    int          f;
    int          r;
    logic [2:0]  op;
    int          pos;
    rst_n   = 1'b0;
    s_valid = 1'b0;
    s_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_item(ilid_pkg::OP_READ, PosW'(0), 32'h1);
    send_item(ilid_pkg::OP_DELETE, PosW'(0), 32'h2);
    send_item(ilid_pkg::OP_INS_AT, PosW'(1), 32'h3);
    send_item(ilid_pkg::OP_INS_AT, '1, 32'h4);
    send_item(ilid_pkg::OP_INS_HEAD, PosW'(0), 32'h7FFF_FFFF);
    send_item(ilid_pkg::OP_INS_TAIL, '1, 32'h8000_0000);
    send_item(ilid_pkg::OP_INS_AT, PosW'(1), 32'h0000_0000);
    send_item(ilid_pkg::OP_INS_AT, PosW'(3), 32'hFFFF_FFFF);
    send_item(ilid_pkg::OP_INS_AT, PosW'(0), 32'h1234_5678);
    for (int i = 0; i < 5; i++) send_item(ilid_pkg::OP_READ, PosW'(i), $urandom);
    send_item(ilid_pkg::OP_READ, PosW'(5), 32'hFFFF_FFFF);
    send_item(ilid_pkg::OP_READ, '1, 32'h0);
    send_item(ilid_pkg::OP_DELETE, PosW'(4), 32'h0);
    send_item(ilid_pkg::OP_DELETE, PosW'(0), 32'hFFFF_FFFF);
    send_item(ilid_pkg::OP_DELETE, '1, 32'h0);
    send_item(ilid_pkg::OP_DELETE, PosW'(1), 32'h0);
    for (int k = ilid_pkg::OP_DELETE + 1; k < 8; k++) send_item(3'(k), '1, $urandom);

    counted    = 0;
    phase_left = PhaseLen;
    target     = Cap;
    while (counted < NumItems) begin
      if (phase_left == 0) begin
        phase_left = PhaseLen;
        case ($urandom_range(0, 2))
          0:       target = 0;
          1:       target = Cap;
          default: target = $urandom_range(0, Cap);
        endcase
      end
      f = int'(fill);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        op  = 3'($urandom_range(0, 7));
        pos = $urandom_range(0, 127);
      end else begin
        r = $urandom_range(0, 99);
        if (f < target) begin
          op = (r < 60) ? ilid_pkg::OP_INS_AT : (r < 75) ? ilid_pkg::OP_DELETE : ilid_pkg::OP_READ;
        end else begin
          op = (r < 15) ? ilid_pkg::OP_INS_AT : (r < 75) ? ilid_pkg::OP_DELETE : ilid_pkg::OP_READ;
        end
        if (op == ilid_pkg::OP_INS_AT) begin
          case ($urandom_range(0, 2))
            0: op = ilid_pkg::OP_INS_HEAD;
            1: op = ilid_pkg::OP_INS_TAIL;
            default: ;
          endcase
          pos = ($urandom_range(0, 19) == 0) ? f + 1 : $urandom_range(0, f);
        end else begin
          pos = (f == 0 || $urandom_range(0, 19) == 0) ? f : $urandom_range(0, f - 1);
        end
      end
      send_item(op, PosW'(pos), pick_value());
      if (op <= ilid_pkg::OP_DELETE) begin
        counted++;
        phase_left--;
      end
    end

    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
